/* sv/bucket_priority_queue_fifo_defines.svh */
// Assertion macros for the bucket priority queue.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef BUCKET_PRIORITY_QUEUE_FIFO_DEFINES_SVH
`define BUCKET_PRIORITY_QUEUE_FIFO_DEFINES_SVH

// Same-cycle check: when ante holds, cons must hold.
`define BPQ_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle check: when ante holds, cons must hold in the next cycle.
`define BPQ_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/bpq_pkg.sv */
// Shared constants and types for the bucket priority queue.
// No dependencies; used by bpq_cell and the top level.
package bpq_pkg;

    // Fixed port widths
    localparam int OP_W    = 2;
    localparam int KEY_W   = 16;
    localparam int VALUE_W = 32;
    localparam int ST_W    = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

    // Keys covered by one occupancy cell
    localparam int CELL_KEYS = 16;
    localparam int CELL_LW   = 4;

    // Command broadcast to every occupancy cell
    typedef struct packed {
        logic set_bit;
        logic clear_bit;
        logic clear_all;
    } cell_cmd_t;

endpackage

/* sv/bpq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/bpq_cell.sv */
// One occupancy cell: holds the occupied bits of CELL_KEYS buckets.
// Depends on bpq_pkg. Cells are chained for the lowest-key search and lookup.
module bpq_cell #(
    parameter int CELL_IDX = 0,
    parameter int CKW      = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  bpq_pkg::cell_cmd_t  cmd,
    input  logic [CKW-1:0]      cmd_key,
    input  logic                found_in,
    input  logic [CKW-1:0]      min_in,
    input  logic                hit_in,
    output logic                found_out,
    output logic [CKW-1:0]      min_out,
    output logic                hit_out
);

    localparam int NK = bpq_pkg::CELL_KEYS;
    localparam int LW = bpq_pkg::CELL_LW;

    logic [NK-1:0] occ_reg;
    logic [NK-1:0] occ_next;
    logic          sel;
    logic [LW-1:0] lo;
    logic [LW-1:0] local_idx;
    logic          local_any;

    // Does the command key fall in this cell
    assign sel = (cmd_key >> LW) == CKW'(CELL_IDX);
    assign lo  = cmd_key[LW-1:0];

    // Occupancy update
    always_comb
    begin
        occ_next = occ_reg;
        if (cmd.clear_all)
        begin
            occ_next = '0;
        end
        else if (sel && cmd.set_bit)
        begin
            occ_next[lo] = 1'b1;
        end
        else if (sel && cmd.clear_bit)
        begin
            occ_next[lo] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    // Lowest occupied bucket within the cell
    always_comb
    begin
        local_idx = '0;
        for (int i = NK - 1; i >= 0; i--)
        begin
            if (occ_reg[i])
            begin
                local_idx = LW'(i);
            end
        end
    end

    assign local_any = |occ_reg;

    // Chain: a lower cell that found a bucket wins
    assign found_out = found_in | local_any;
    assign min_out   = found_in ? min_in : (CKW'(CELL_IDX * NK) + CKW'(local_idx));
    assign hit_out   = hit_in | (sel & occ_reg[lo]);

endmodule

/* sv/bucket_priority_queue_fifo.sv */
// Bucket priority queue: top level with control, slot pool and memories.
// Depends on bpq_pkg, bpq_ram, bpq_cell and bucket_priority_queue_fifo_defines.svh.
//
// Usage:
//   cmd channel (cmd_valid/cmd_ready) carries operation, key and entry_value.
//   res channel (res_valid/res_ready) returns removed_value, removed_key,
//   status, entry_count and queue_empty; every item gives exactly one result.
//   Steps from acceptance to a registered result:
//     clear, unused codes, rejected inserts and remove on empty: loaded on acceptance,
//     insert: tail and free-list read, then link write,
//     remove: head/tail read, link and payload read, update.
//   One item is in flight at a time: no new item is accepted until the last one
//   has its result; the steps follow from the dependent reads of the head and link memories.
//   The lowest occupied key is found in the same cycle by a row of occupancy
//   cells, 16 keys per cell, chained from key 0 upward.
//   Reset empties the queue at once: occupancy bits, slot pool and count
//   clear, memories keep stale data that is never read.
//   When the receiver stalls, the result is held and no item is accepted
//   until it is taken; a result taken in the same cycle frees the slot.
`include "bucket_priority_queue_fifo_defines.svh"

module bucket_priority_queue_fifo #(
    parameter int KEY_LEVELS = 256,
    parameter int CAPACITY   = 1024,
    parameter int ENTRY_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    output logic                                cmd_ready,
    input  logic [bpq_pkg::OP_W-1:0]            operation,
    input  logic [bpq_pkg::KEY_W-1:0]           key,
    input  logic [bpq_pkg::VALUE_W-1:0]         entry_value,
    output logic                                res_valid,
    input  logic                                res_ready,
    output logic [bpq_pkg::VALUE_W-1:0]         removed_value,
    output logic [bpq_pkg::KEY_W-1:0]           removed_key,
    output logic [bpq_pkg::ST_W-1:0]            status,
    output logic [$clog2(CAPACITY+1)-1:0]       entry_count,
    output logic                                queue_empty
);

    localparam int KW        = $clog2(KEY_LEVELS);
    localparam int SW        = $clog2(CAPACITY);
    localparam int PW        = $clog2(CAPACITY + 1);
    localparam int LW        = bpq_pkg::CELL_LW;
    localparam int CKW       = (KW > LW) ? KW : LW;
    localparam int NUM_CELLS = (KEY_LEVELS + bpq_pkg::CELL_KEYS - 1) / bpq_pkg::CELL_KEYS;
    localparam int VW        = bpq_pkg::VALUE_W;
    localparam int KEYW      = bpq_pkg::KEY_W;
    localparam int STORE_W   = (ENTRY_BITS < VW) ? ENTRY_BITS : VW;

    // Sequencer states
    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_INS     = 2'd1;
    localparam logic [1:0] S_RM_HEAD = 2'd2;
    localparam logic [1:0] S_RM_POP  = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [PW-1:0] fresh_reg, fresh_next;
    logic [PW-1:0] free_head_reg, free_head_next;
    logic [PW-1:0] count_reg, count_next;
    logic          res_valid_reg, res_valid_next;

    logic [KW-1:0]      key_reg;
    logic [STORE_W-1:0] value_reg;
    logic [KW-1:0]      min_key_reg;
    logic [SW-1:0]      slot_reg;
    logic               tail_match_reg;

    logic [VW-1:0]             removed_value_reg, removed_value_next;
    logic [KEYW-1:0]           removed_key_reg, removed_key_next;
    logic [bpq_pkg::ST_W-1:0]  status_reg, status_next;
    logic [PW-1:0]             entry_count_reg;
    logic                      queue_empty_reg;
    logic                      res_load;

    logic accept;
    logic key_ok;
    logic full;
    logic list_empty;
    logic free_nonempty;
    logic [SW-1:0] ins_slot;
    logic [KW-1:0] min_key;
    logic          any_occ;
    logic          occ_hit;

    // Memory ports
    logic          head_we, tail_we, next_we, pay_we;
    logic [KW-1:0] head_waddr, tail_waddr, tail_raddr;
    logic [SW-1:0] head_wdata, tail_wdata, head_rdata, tail_rdata;
    logic [SW-1:0] next_waddr, next_raddr, pay_waddr;
    logic [PW-1:0] next_wdata, next_rdata;
    logic [STORE_W-1:0] pay_wdata, pay_rdata;

    // Occupancy cell row
    bpq_pkg::cell_cmd_t cell_cmd;
    logic [CKW-1:0]     cell_key;
    logic               found_chain [NUM_CELLS+1];
    logic [CKW-1:0]     min_chain   [NUM_CELLS+1];
    logic               hit_chain   [NUM_CELLS+1];

    assign found_chain[0] = 1'b0;
    assign min_chain[0]   = '0;
    assign hit_chain[0]   = 1'b0;
    assign cell_key       = CKW'((state_reg == S_INS) ? key_reg : min_key_reg);

    for (genvar c = 0; c < NUM_CELLS; c++)
    begin : g_cell
        bpq_cell #(
            .CELL_IDX (c),
            .CKW      (CKW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cell_cmd),
            .cmd_key   (cell_key),
            .found_in  (found_chain[c]),
            .min_in    (min_chain[c]),
            .hit_in    (hit_chain[c]),
            .found_out (found_chain[c+1]),
            .min_out   (min_chain[c+1]),
            .hit_out   (hit_chain[c+1])
        );
    end

    assign any_occ = found_chain[NUM_CELLS];
    assign min_key = min_chain[NUM_CELLS][KW-1:0];
    assign occ_hit = hit_chain[NUM_CELLS];

    // Handshake and item checks
    assign cmd_ready     = (state_reg == S_IDLE) && (!res_valid_reg || res_ready);
    assign accept        = cmd_valid && cmd_ready;
    assign key_ok        = 32'(key) < KEY_LEVELS;
    assign full          = count_reg >= PW'(CAPACITY);
    assign list_empty    = !any_occ || (count_reg == '0);
    assign free_nonempty = free_head_reg < PW'(CAPACITY);
    assign ins_slot      = free_nonempty ? free_head_reg[SW-1:0] : fresh_reg[SW-1:0];

    // Read addresses
    assign tail_raddr = (operation == bpq_pkg::OP_REMOVE) ? min_key : key[KW-1:0];
    assign next_raddr = (state_reg == S_RM_HEAD) ? head_rdata :
                        (free_nonempty ? free_head_reg[SW-1:0] : '0);

    // Sequencer and update logic
    always_comb
    begin
        state_next         = state_reg;
        fresh_next         = fresh_reg;
        free_head_next     = free_head_reg;
        count_next         = count_reg;
        res_valid_next     = res_valid_reg && !res_ready;
        res_load           = 1'b0;
        removed_value_next = '0;
        removed_key_next   = '0;
        status_next        = bpq_pkg::ST_OK;
        cell_cmd           = '0;
        head_we            = 1'b0;
        head_waddr         = key_reg;
        head_wdata         = ins_slot;
        tail_we            = 1'b0;
        tail_waddr         = key_reg;
        tail_wdata         = ins_slot;
        next_we            = 1'b0;
        next_waddr         = tail_rdata;
        next_wdata         = PW'(ins_slot);
        pay_we             = 1'b0;
        pay_waddr          = ins_slot;
        pay_wdata          = value_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (operation)
                        bpq_pkg::OP_INSERT:
                        begin
                            if (!key_ok)
                            begin
                                res_load    = 1'b1;
                                status_next = bpq_pkg::ST_RANGE;
                            end
                            else if (full)
                            begin
                                res_load    = 1'b1;
                                status_next = bpq_pkg::ST_FULL;
                            end
                            else
                            begin
                                state_next = S_INS;
                            end
                        end
                        bpq_pkg::OP_REMOVE:
                        begin
                            if (list_empty)
                            begin
                                res_load    = 1'b1;
                                status_next = bpq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_RM_HEAD;
                            end
                        end
                        bpq_pkg::OP_CLEAR:
                        begin
                            cell_cmd.clear_all = 1'b1;
                            fresh_next         = '0;
                            free_head_next     = PW'(CAPACITY);
                            count_next         = '0;
                            res_load           = 1'b1;
                        end
                        default:
                        begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            S_INS:
            begin
                // take a slot, store payload, link it at the bucket tail (or make it the head of an empty bucket)
                if (free_nonempty)
                begin
                    free_head_next = next_rdata;
                end
                else
                begin
                    fresh_next = fresh_reg + PW'(1);
                end
                pay_we = 1'b1;
                if (occ_hit)
                begin
                    next_we = 1'b1;
                end
                else
                begin
                    head_we = 1'b1;
                end
                tail_we          = 1'b1;
                cell_cmd.set_bit = 1'b1;
                count_next       = count_reg + PW'(1);
                res_load         = 1'b1;
                state_next       = S_IDLE;
            end
            S_RM_HEAD:
            begin
                state_next = S_RM_POP;
            end
            S_RM_POP:
            begin
                // unlink the head slot and push it on the free list; clear the bucket's bit if it was the last
                removed_value_next = VW'(pay_rdata);
                removed_key_next   = KEYW'(min_key_reg);
                head_waddr         = min_key_reg;
                head_wdata         = next_rdata[SW-1:0];
                if (tail_match_reg)
                begin
                    cell_cmd.clear_bit = 1'b1;
                end
                else
                begin
                    head_we = 1'b1;
                end
                next_we        = 1'b1;
                next_waddr     = slot_reg;
                next_wdata     = free_head_reg;
                free_head_next = PW'(slot_reg);
                count_next     = count_reg - PW'(1);
                res_load       = 1'b1;
                state_next     = S_IDLE;
            end
        endcase

        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fresh_reg     <= '0;
            free_head_reg <= PW'(CAPACITY);
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fresh_reg     <= fresh_next;
            free_head_reg <= free_head_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Item and result payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg     <= key[KW-1:0];
            value_reg   <= entry_value[STORE_W-1:0];
            min_key_reg <= min_key;
        end
        if (state_reg == S_RM_HEAD)
        begin
            slot_reg       <= head_rdata;
            tail_match_reg <= (tail_rdata == head_rdata);
        end
        if (res_load)
        begin
            removed_value_reg <= removed_value_next;
            removed_key_reg   <= removed_key_next;
            status_reg        <= status_next;
            entry_count_reg   <= count_next;
            queue_empty_reg   <= (count_next == '0);
        end
    end

    // Bucket head and tail memories, slot link and payload memories
    bpq_ram #(.WIDTH(SW), .DEPTH(KEY_LEVELS)) u_head_ram (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .raddr (min_key),
        .rdata (head_rdata)
    );

    bpq_ram #(.WIDTH(SW), .DEPTH(KEY_LEVELS)) u_tail_ram (
        .clk   (clk),
        .we    (tail_we),
        .waddr (tail_waddr),
        .wdata (tail_wdata),
        .raddr (tail_raddr),
        .rdata (tail_rdata)
    );

    bpq_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_next_ram (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .raddr (next_raddr),
        .rdata (next_rdata)
    );

    bpq_ram #(.WIDTH(STORE_W), .DEPTH(CAPACITY)) u_pay_ram (
        .clk   (clk),
        .we    (pay_we),
        .waddr (pay_waddr),
        .wdata (pay_wdata),
        .raddr (head_rdata),
        .rdata (pay_rdata)
    );

    // Outputs
    assign res_valid     = res_valid_reg;
    assign removed_value = removed_value_reg;
    assign removed_key   = removed_key_reg;
    assign status        = status_reg;
    assign entry_count   = entry_count_reg;
    assign queue_empty   = queue_empty_reg;

    // Checks
    `BPQ_CHECK(a_count_bound, 1'b1, count_reg <= PW'(CAPACITY), "stored count above capacity")
    `BPQ_CHECK(a_count_vs_cells, 1'b1, (count_reg == '0) == !any_occ, "count and occupancy disagree")
    `BPQ_CHECK(a_full_count, res_valid_reg && (status_reg == bpq_pkg::ST_FULL), entry_count_reg == PW'(CAPACITY), "full status below capacity")
    `BPQ_CHECK(a_empty_flag, res_valid_reg, queue_empty_reg == (entry_count_reg == '0), "empty flag mismatch")
    `BPQ_CHECK_NEXT(a_insert_done, state_reg == S_INS, res_valid_reg && (state_reg == S_IDLE), "insert did not complete")

endmodule
